[sv/skvt_pkg.sv]
// Shared types and codes for the sorted key/value table.
// No dependencies; imported by the controller, datapath and top level.
package skvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int CNT_O_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP     = 2'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

endpackage

[sv/skvt_ctrl.sv]
// Controller for the sorted key/value table: sequences accept and commit,
// owns the output valid. Depends on skvt_pkg.
module skvt_ctrl
    import skvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: if (o_cmd.commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/skvt_dp.sv]
// Datapath for the sorted key/value table: row of key/value cells with
// parallel compare, one-step shift, count and result registers. Depends on skvt_pkg.
module skvt_dp
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CW       = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [OP_W-1:0]        i_opcode,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0]       i_value_in,
    output logic [ST_W-1:0]        o_status,
    output logic [VAL_W-1:0]       o_value_out,
    output logic [CNT_O_W-1:0]     o_entry_count,
    output logic [CW-1:0]          o_count
);

    logic signed [KEY_W-1:0] r_key  [CAPACITY];
    logic [VAL_W-1:0]        r_val  [CAPACITY];
    logic signed [KEY_W-1:0] n_key  [CAPACITY];
    logic [VAL_W-1:0]        n_val  [CAPACITY];

    logic [CW-1:0]           r_count, n_count;
    logic [OP_W-1:0]         r_op;
    logic signed [KEY_W-1:0] r_in_key;
    logic [VAL_W-1:0]        r_in_val;
    logic [CAPACITY-1:0]     r_eq, r_lt, n_eq, n_lt;

    logic [ST_W-1:0]         r_status, n_status;
    logic [VAL_W-1:0]        r_vout, n_vout;
    logic [CNT_O_W-1:0]      r_cnt_out;
    logic [CW+CNT_O_W-1:0]   w_cnt_ext;

    logic hit, full, ins_ok, del_ok, upd_ok;
    logic [VAL_W-1:0] found;

    // parallel compare against the incoming key, registered at accept
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_eq[i] = (CW'(i) < r_count) && (r_key[i] == i_key);
            n_lt[i] = (CW'(i) < r_count) && (r_key[i] < i_key);
        end
    end

    always_comb begin
        hit    = |r_eq;
        full   = (r_count == CW'(CAPACITY));
        ins_ok = (r_op == OP_INSERT) && !full && !hit;
        del_ok = (r_op == OP_DELETE) && hit;
        upd_ok = (r_op == OP_UPDATE) && hit;
        found  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_eq[i]) found = found | r_val[i];
        end
        n_count = r_count;
        if (ins_ok) n_count = r_count + CW'(1);
        if (del_ok) n_count = r_count - CW'(1);
        n_vout = '0;
        if (r_op == OP_INSERT) begin
            priority if (full) n_status = ST_FULL;
            else if (hit)      n_status = ST_DUP;
            else               n_status = ST_OK;
        end else begin
            n_status = hit ? ST_OK : ST_MISSING;
            if (r_op == OP_LOOKUP && hit) n_vout = found;
        end
    end

    // cells below the insert point keep; the insert point takes the new entry;
    // above it takes the lower neighbor. Delete pulls from the upper neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic at_pos;
        logic signed [KEY_W-1:0] lo_key, hi_key;
        logic [VAL_W-1:0]        lo_val, hi_val;
        if (g == 0) begin : g_first
            assign at_pos = 1'b1;
            assign lo_key = r_key[g];
            assign lo_val = r_val[g];
        end else begin : g_rest
            assign at_pos = r_lt[g-1];
            assign lo_key = r_key[g-1];
            assign lo_val = r_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign hi_key = r_key[g];
            assign hi_val = r_val[g];
        end else begin : g_mid
            assign hi_key = r_key[g+1];
            assign hi_val = r_val[g+1];
        end

        always_comb begin
            n_key[g] = r_key[g];
            n_val[g] = r_val[g];
            if (ins_ok) begin
                if (!r_lt[g]) begin
                    if (at_pos) begin
                        n_key[g] = r_in_key;
                        n_val[g] = r_in_val;
                    end else begin
                        n_key[g] = lo_key;
                        n_val[g] = lo_val;
                    end
                end
            end else if (del_ok) begin
                if (!r_lt[g]) begin
                    n_key[g] = hi_key;
                    n_val[g] = hi_val;
                end
            end else if (upd_ok) begin
                if (r_eq[g]) n_val[g] = r_in_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.commit) begin
                r_key[g] <= n_key[g];
                r_val[g] <= n_val[g];
            end
        end
    end

    assign w_cnt_ext = {{CNT_O_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_in_key <= i_key;
            r_in_val <= i_value_in;
            r_eq     <= n_eq;
            r_lt     <= n_lt;
        end
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_vout    <= n_vout;
            r_cnt_out <= w_cnt_ext[CNT_O_W-1:0];
        end
    end

    assign o_status      = r_status;
    assign o_value_out   = r_vout;
    assign o_entry_count = r_cnt_out;
    assign o_count       = r_count;

endmodule

[sv/sorted_key_value_table_unit.sv]
// Sorted key/value table: up to CAPACITY unique signed keys with values,
// kept in key order in a row of register cells. The accepting beat compares
// the key against every cell at once and registers the match and less-than
// flags; in the execute state that follows, all cells shift or update in one
// step and the result register loads. The input is stalled throughout the
// execute state, which is held while a finished result is held by a stall
// on the output. Entry count leaves the block masked to 5 bits.
// Depends on skvt_pkg, skvt_ctrl, skvt_dp.
module sorted_key_value_table_unit
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0]        i_value_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ST_W-1:0]         o_status,
    output logic [VAL_W-1:0]        o_value_out,
    output logic [CNT_O_W-1:0]      o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_cmd       w_cmd;
    logic [CW-1:0] w_count;

    skvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    skvt_dp #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count),
        .o_count       (w_count)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted a beat while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (w_count == CW'(CAPACITY)))
        else $error("full status with free slots");

    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_value_out != '0) |-> (o_status == ST_OK))
        else $error("value returned on failed operation");

endmodule
